// ===== rtl/core/sct_pkg.sv =====
// Shared constants and helper functions of the source code tokenizer.
package sct_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 20;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned LINE_BITS_DEF   = 16;

  localparam int unsigned KIND_BITS = 6;
  localparam int unsigned ERR_BITS  = 2;

  // Token kinds.
  localparam logic [KIND_BITS-1:0] K_ERROR    = 6'd0;
  localparam logic [KIND_BITS-1:0] K_EOF      = 6'd1;
  localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd2;
  localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd3;
  localparam logic [KIND_BITS-1:0] K_LBRACKET = 6'd4;
  localparam logic [KIND_BITS-1:0] K_RBRACKET = 6'd5;
  localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd6;
  localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd7;
  localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd8;
  localparam logic [KIND_BITS-1:0] K_DOT      = 6'd9;
  localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd10;
  localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd12;
  localparam logic [KIND_BITS-1:0] K_STAR     = 6'd14;
  localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd16;
  localparam logic [KIND_BITS-1:0] K_SLASH_EQ = 6'd17;
  localparam logic [KIND_BITS-1:0] K_BANG     = 6'd18;
  localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd20;
  localparam logic [KIND_BITS-1:0] K_GREATER  = 6'd22;
  localparam logic [KIND_BITS-1:0] K_LESS     = 6'd24;
  localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd26;
  localparam logic [KIND_BITS-1:0] K_STRING   = 6'd27;
  localparam logic [KIND_BITS-1:0] K_NUMBER   = 6'd28;
  localparam logic [KIND_BITS-1:0] K_LET      = 6'd29;
  localparam logic [KIND_BITS-1:0] K_IF       = 6'd30;
  localparam logic [KIND_BITS-1:0] K_ELSE     = 6'd31;
  localparam logic [KIND_BITS-1:0] K_WHILE    = 6'd32;
  localparam logic [KIND_BITS-1:0] K_FUNC     = 6'd33;
  localparam logic [KIND_BITS-1:0] K_RETURN   = 6'd34;
  localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd35;

  // Error codes.
  localparam logic [ERR_BITS-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_STR_NL  = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_STR_END = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_UNKNOWN = 2'd3;

  // Characters.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword spellings, first character in the low byte.
  localparam logic [47:0] KW_LET    = 48'h0000_0074_656C;
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
  localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6C65;
  localparam logic [47:0] KW_WHILE  = 48'h0065_6C69_6877;
  localparam logic [47:0] KW_FUNC   = 48'h0000_636E_7566;
  localparam logic [47:0] KW_RETURN = 48'h6E72_7574_6572;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
  endfunction

  function automatic logic [KIND_BITS-1:0] op_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      CH_MINUS: k = K_MINUS;
      CH_PLUS:  k = K_PLUS;
      CH_STAR:  k = K_STAR;
      CH_EQ:    k = K_ASSIGN;
      CH_GT:    k = K_GREATER;
      CH_LESS:  k = K_LESS;
      default:  k = K_BANG;
    endcase
    return k;
  endfunction

  // len is the word length clipped to seven.
  function automatic logic [KIND_BITS-1:0] kw_kind(input logic [47:0] prefix,
                                                   input logic [2:0] len);
    logic [KIND_BITS-1:0] k;
    k = K_IDENT;
    if (len == 3'd3 && prefix == KW_LET) k = K_LET;
    if (len == 3'd2 && prefix == KW_IF) k = K_IF;
    if (len == 3'd4 && prefix == KW_ELSE) k = K_ELSE;
    if (len == 3'd5 && prefix == KW_WHILE) k = K_WHILE;
    if (len == 3'd4 && prefix == KW_FUNC) k = K_FUNC;
    if (len == 3'd6 && prefix == KW_RETURN) k = K_RETURN;
    return k;
  endfunction

endpackage

// ===== rtl/core/sct_if.sv =====
// Channel interfaces of the tokenizer: source bytes in, tokens out.
interface sct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, output source_byte, output end_of_source, input ready);
  modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

interface sct_token_if #(
  parameter int unsigned OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = sct_pkg::LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = sct_pkg::LINE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [sct_pkg::KIND_BITS-1:0] token_kind;
  logic [OFFSET_BITS-1:0]       token_start;
  logic [LENGTH_BITS-1:0]       token_length;
  logic [LINE_BITS-1:0]         token_line;
  logic [sct_pkg::ERR_BITS-1:0] error_kind;
  logic                         last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output token_line, output error_kind, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input token_line, input error_kind, input last_of_run, output ready);
endinterface

// ===== rtl/core/source_code_tokenizer.sv =====
// Streaming lexical scanner: one source byte per request, tokens out.
// A token is written into the token queue when the request that completes it is taken.
// Throughput: one byte per cycle; the four-entry token queue drains one token per
// cycle while the sink is ready, and a request is taken while at least two entries
// are free. An item that ends two tokens therefore takes two queue entries.
// Reset (asynchronous, active low) returns the scanner to idle and empties the queue.
module source_code_tokenizer #(
  parameter int unsigned OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = sct_pkg::LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = sct_pkg::LINE_BITS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  sct_byte_if.sink     in_i,
  sct_token_if.source  tok_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_OP, M_NUM, M_FRAC, M_WORD, M_STR, M_ESC, M_LINE, M_BLOCK, M_BSTAR
  } mode_e;

  typedef struct packed {
    logic [sct_pkg::KIND_BITS-1:0] kind;
    logic [OFFSET_BITS-1:0]        start;
    logic [LENGTH_BITS-1:0]        len;
    logic [LINE_BITS-1:0]          line;
    logic [sct_pkg::ERR_BITS-1:0]  err;
    logic                          last;
  } tok_t;

  mode_e                  mode_q, mode_d;
  logic [7:0]             held_q, held_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0] run_q, run_d, run_grow;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [47:0]            prefix_q, prefix_d;
  logic                   line_inc;

  tok_t       fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;

  logic       acc, pop;
  logic [7:0] c;
  logic       pend, a_v, b_v, i_v, do_flush, do_idle, clear;
  tok_t       flush_tok, a, b, i_tok;
  logic [2:0] len3;

  assign acc = in_i.valid & in_i.ready;
  assign pop = tok_o.valid & tok_o.ready;
  assign c   = in_i.source_byte;

  assign run_grow = (&run_q) ? run_q : run_q + LENGTH_BITS'(1);
  assign len3     = (run_q > LENGTH_BITS'(6)) ? 3'd7 : run_q[2:0];

  // Token held back in a lookahead mode.
  always_comb begin
    pend      = 1'b1;
    flush_tok = '0;
    flush_tok.start = start_q;
    flush_tok.line  = line_q;
    flush_tok.err   = sct_pkg::ERR_NONE;
    flush_tok.len   = run_q;
    case (mode_q)
      M_SLASH: begin
        flush_tok.kind = sct_pkg::K_SLASH;
        flush_tok.len  = LENGTH_BITS'(1);
      end
      M_OP: begin
        flush_tok.kind = sct_pkg::op_kind(held_q);
        flush_tok.len  = LENGTH_BITS'(1);
      end
      M_NUM, M_FRAC: flush_tok.kind = sct_pkg::K_NUMBER;
      M_WORD: flush_tok.kind = sct_pkg::kw_kind(prefix_q, len3);
      default: pend = 1'b0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    off_d    = off_q + OFFSET_BITS'(1);
    start_d  = start_q;
    run_d    = run_q;
    prefix_d = prefix_q;
    line_inc = 1'b0;
    clear    = 1'b0;
    do_flush = 1'b0;
    do_idle  = 1'b0;
    a_v      = 1'b0;
    a        = flush_tok;
    b_v      = 1'b0;
    b        = flush_tok;
    i_v      = 1'b0;
    i_tok    = '0;
    i_tok.start = off_q;
    i_tok.len   = LENGTH_BITS'(1);
    i_tok.line  = line_q;
    i_tok.err   = sct_pkg::ERR_NONE;

    if (in_i.end_of_source) begin
      if (mode_q == M_STR || mode_q == M_ESC) begin
        a_v   = 1'b1;
        a.kind = sct_pkg::K_ERROR;
        a.len  = run_q;
        a.err  = sct_pkg::ERR_STR_END;
      end else begin
        a_v = pend;
      end
      i_v        = 1'b1;
      i_tok.kind = sct_pkg::K_EOF;
      i_tok.len  = '0;
      clear      = 1'b1;
    end else begin
      case (mode_q)
        M_SLASH: begin
          if (c == sct_pkg::CH_SLASH) mode_d = M_LINE;
          else if (c == sct_pkg::CH_STAR) mode_d = M_BLOCK;
          else if (c == sct_pkg::CH_EQ) begin
            a_v    = 1'b1;
            a.kind = sct_pkg::K_SLASH_EQ;
            a.len  = LENGTH_BITS'(2);
            mode_d = M_IDLE;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_OP: begin
          if (c == sct_pkg::CH_EQ) begin
            a_v    = 1'b1;
            a.kind = sct_pkg::op_kind(held_q) + sct_pkg::KIND_BITS'(1);
            a.len  = LENGTH_BITS'(2);
            mode_d = M_IDLE;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_NUM: begin
          if (sct_pkg::is_digit(c)) run_d = run_grow;
          else if (c == sct_pkg::CH_DOT) begin
            run_d  = run_grow;
            mode_d = M_FRAC;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_FRAC: begin
          if (sct_pkg::is_digit(c)) run_d = run_grow;
          else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_WORD: begin
          if (sct_pkg::is_alpha(c) || sct_pkg::is_digit(c)) begin
            // Only the first six characters are kept for the keyword match.
            for (int k = 1; k < 6; k++) begin
              if (run_q == LENGTH_BITS'(k)) prefix_d[8*k +: 8] = c;
            end
            run_d = run_grow;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_STR: begin
          if (c == sct_pkg::CH_QUOTE) begin
            a_v    = 1'b1;
            a.kind = sct_pkg::K_STRING;
            mode_d = M_IDLE;
          end else if (c == sct_pkg::CH_LF) begin
            a_v     = 1'b1;
            a.kind  = sct_pkg::K_ERROR;
            a.err   = sct_pkg::ERR_STR_NL;
            do_idle = 1'b1;
          end else if (c == sct_pkg::CH_BSLASH) begin
            run_d  = run_grow;
            mode_d = M_ESC;
          end else begin
            run_d = run_grow;
          end
        end
        M_ESC: begin
          run_d    = run_grow;
          line_inc = (c == sct_pkg::CH_LF);
          mode_d   = M_STR;
        end
        M_LINE: begin
          if (c == sct_pkg::CH_LF) begin
            line_inc = 1'b1;
            mode_d   = M_IDLE;
          end
        end
        M_BLOCK: begin
          if (c == sct_pkg::CH_STAR) mode_d = M_BSTAR;
        end
        M_BSTAR: begin
          if (c == sct_pkg::CH_SLASH) mode_d = M_IDLE;
          else if (c != sct_pkg::CH_STAR) mode_d = M_BLOCK;
        end
        default: do_idle = 1'b1;
      endcase

      if (do_flush) begin
        a_v = pend;
        a   = flush_tok;
      end

      if (do_idle) begin
        mode_d = M_IDLE;
        case (c)
          sct_pkg::CH_SPACE, sct_pkg::CH_CR, sct_pkg::CH_TAB: ;
          sct_pkg::CH_LF: line_inc = 1'b1;
          sct_pkg::CH_LPAREN: begin i_v = 1'b1; i_tok.kind = sct_pkg::K_LPAREN; end
          sct_pkg::CH_RPAREN: begin i_v = 1'b1; i_tok.kind = sct_pkg::K_RPAREN; end
          sct_pkg::CH_LBRACK: begin i_v = 1'b1; i_tok.kind = sct_pkg::K_LBRACKET; end
          sct_pkg::CH_RBRACK: begin i_v = 1'b1; i_tok.kind = sct_pkg::K_RBRACKET; end
          sct_pkg::CH_LBRACE: begin i_v = 1'b1; i_tok.kind = sct_pkg::K_LBRACE; end
          sct_pkg::CH_RBRACE: begin i_v = 1'b1; i_tok.kind = sct_pkg::K_RBRACE; end
          sct_pkg::CH_COMMA:  begin i_v = 1'b1; i_tok.kind = sct_pkg::K_COMMA; end
          sct_pkg::CH_DOT:    begin i_v = 1'b1; i_tok.kind = sct_pkg::K_DOT; end
          sct_pkg::CH_SEMI:   begin i_v = 1'b1; i_tok.kind = sct_pkg::K_SEMI; end
          sct_pkg::CH_SLASH: begin
            mode_d  = M_SLASH;
            start_d = off_q;
          end
          sct_pkg::CH_BANG, sct_pkg::CH_EQ, sct_pkg::CH_GT, sct_pkg::CH_LESS,
          sct_pkg::CH_MINUS, sct_pkg::CH_PLUS, sct_pkg::CH_STAR: begin
            mode_d  = M_OP;
            held_d  = c;
            start_d = off_q;
          end
          sct_pkg::CH_QUOTE: begin
            // The string token starts after the opening quote.
            mode_d  = M_STR;
            start_d = off_q + OFFSET_BITS'(1);
            run_d   = '0;
          end
          default: begin
            if (sct_pkg::is_digit(c)) begin
              mode_d  = M_NUM;
              start_d = off_q;
              run_d   = LENGTH_BITS'(1);
            end else if (sct_pkg::is_alpha(c)) begin
              mode_d   = M_WORD;
              start_d  = off_q;
              run_d    = LENGTH_BITS'(1);
              prefix_d = {40'd0, c};
            end else begin
              i_v        = 1'b1;
              i_tok.kind = sct_pkg::K_ERROR;
              i_tok.err  = sct_pkg::ERR_UNKNOWN;
            end
          end
        endcase
      end
    end

    // The token started by this byte goes behind any token it closed.
    if (i_v) begin
      if (a_v) begin
        b_v = 1'b1;
        b   = i_tok;
      end else begin
        a_v = 1'b1;
        a   = i_tok;
      end
    end
    a.last = ~b_v;
    b.last = 1'b1;

    line_d = (line_inc && !(&line_q)) ? line_q + LINE_BITS'(1) : line_q;

    if (clear) begin
      mode_d   = M_IDLE;
      held_d   = '0;
      off_d    = '0;
      start_d  = '0;
      run_d    = '0;
      line_d   = '0;
      prefix_d = '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (acc) cnt_d = cnt_d + {2'd0, a_v} + {2'd0, b_v};
    if (pop) cnt_d = cnt_d - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      held_q   <= '0;
      off_q    <= '0;
      start_q  <= '0;
      run_q    <= '0;
      line_q   <= '0;
      prefix_q <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
    end else begin
      if (acc) begin
        mode_q   <= mode_d;
        held_q   <= held_d;
        off_q    <= off_d;
        start_q  <= start_d;
        run_q    <= run_d;
        line_q   <= line_d;
        prefix_q <= prefix_d;
        wr_q     <= wr_q + {1'b0, a_v} + {1'b0, b_v};
      end
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && a_v) fifo_q[wr_q] <= a;
    if (acc && b_v) fifo_q[wr_q + 2'd1] <= b;
  end

  assign in_i.ready         = (cnt_q <= 3'd2);
  assign tok_o.valid        = (cnt_q != 3'd0);
  assign tok_o.token_kind   = fifo_q[rd_q].kind;
  assign tok_o.token_start  = fifo_q[rd_q].start;
  assign tok_o.token_length = fifo_q[rd_q].len;
  assign tok_o.token_line   = fifo_q[rd_q].line;
  assign tok_o.error_kind   = fifo_q[rd_q].err;
  assign tok_o.last_of_run  = fifo_q[rd_q].last;

endmodule

// ===== tb/source_code_tokenizer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the source code tokenizer with its own scanner model.
module source_code_tokenizer_test;

  localparam int unsigned OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF;
  localparam int unsigned LENGTH_BITS = sct_pkg::LENGTH_BITS_DEF;
  localparam int unsigned LINE_BITS   = sct_pkg::LINE_BITS_DEF;
  localparam int LENGTH_MAX  = (1 << LENGTH_BITS) - 1;
  localparam int LINE_MAX    = (1 << LINE_BITS) - 1;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_SLASH, SCAN_OP, SCAN_NUM, SCAN_FRAC, SCAN_WORD,
    SCAN_STR, SCAN_ESC, SCAN_LINE_CMT, SCAN_BLOCK_CMT, SCAN_BLOCK_STAR
  } scan_mode_e;

  typedef struct packed {
    logic [sct_pkg::KIND_BITS-1:0] kind;
    logic [OFFSET_BITS-1:0]        start;
    logic [LENGTH_BITS-1:0]        length;
    logic [LINE_BITS-1:0]          line;
    logic [sct_pkg::ERR_BITS-1:0]  err;
    logic                          last;
  } token_t;

  logic clk_i;
  logic rst_ni;

  sct_byte_if  in_ch ();
  sct_token_if #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS),
                 .LINE_BITS(LINE_BITS)) tok_ch ();

  source_code_tokenizer #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS),
    .LINE_BITS  (LINE_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .tok_o (tok_ch)
  );

  token_t expected_tokens[$];
  logic [7:0] src_text[$];
  int error_count;
  int sent_items;
  int send_gap_pct;
  int stall_pct;
  int cycle_count = 0;

  // Scanner state of the model.
  scan_mode_e             scan_mode;
  logic [7:0]             held_op;
  logic [OFFSET_BITS-1:0] src_offset;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [LENGTH_BITS-1:0] run_len;
  logic [LINE_BITS-1:0]   line_no;
  logic [47:0]            word_head;

  string keyword_text[6] = '{"let", "if", "else", "while", "func", "return"};
  string operator_text[16] = '{"!", "!=", "=", "==", ">", ">=", "<", "<=",
                               "-", "-=", "+", "+=", "*", "*=", "/", "/="};
  string punct_text = "()[]{},.;";

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[source_code_tokenizer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_scanner();
    scan_mode  = SCAN_IDLE;
    held_op    = '0;
    src_offset = '0;
    tok_start  = '0;
    run_len    = '0;
    line_no    = '0;
    word_head  = '0;
  endfunction

  function automatic void add_token(logic [sct_pkg::KIND_BITS-1:0] kind,
                                    logic [OFFSET_BITS-1:0] start,
                                    logic [LENGTH_BITS-1:0] len,
                                    logic [sct_pkg::ERR_BITS-1:0] err);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.line   = line_no;
    t.err    = err;
    t.last   = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void grow_run();
    if (run_len != LENGTH_BITS'(LENGTH_MAX)) run_len++;
  endfunction

  function automatic void count_line();
    if (line_no != LINE_BITS'(LINE_MAX)) line_no++;
  endfunction

  function automatic logic char_is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic char_is_letter(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  function automatic logic [sct_pkg::KIND_BITS-1:0] operator_kind(logic [7:0] c);
    case (c)
      sct_pkg::CH_MINUS: return sct_pkg::K_MINUS;
      sct_pkg::CH_PLUS:  return sct_pkg::K_PLUS;
      sct_pkg::CH_STAR:  return sct_pkg::K_STAR;
      sct_pkg::CH_EQ:    return sct_pkg::K_ASSIGN;
      sct_pkg::CH_GT:    return sct_pkg::K_GREATER;
      sct_pkg::CH_LESS:  return sct_pkg::K_LESS;
      default:           return sct_pkg::K_BANG;
    endcase
  endfunction

  function automatic logic [sct_pkg::KIND_BITS-1:0] word_kind();
    logic [sct_pkg::KIND_BITS-1:0] k;
    k = sct_pkg::K_IDENT;
    case (run_len)
      2: if (word_head == sct_pkg::KW_IF) k = sct_pkg::K_IF;
      3: if (word_head == sct_pkg::KW_LET) k = sct_pkg::K_LET;
      4: begin
        if (word_head == sct_pkg::KW_ELSE) k = sct_pkg::K_ELSE;
        else if (word_head == sct_pkg::KW_FUNC) k = sct_pkg::K_FUNC;
      end
      5: if (word_head == sct_pkg::KW_WHILE) k = sct_pkg::K_WHILE;
      6: if (word_head == sct_pkg::KW_RETURN) k = sct_pkg::K_RETURN;
      default: ;
    endcase
    return k;
  endfunction

  // Emits the token that waited for one character of lookahead.
  function automatic void flush_pending();
    case (scan_mode)
      SCAN_SLASH: add_token(sct_pkg::K_SLASH, tok_start, 1, sct_pkg::ERR_NONE);
      SCAN_OP: add_token(operator_kind(held_op), tok_start, 1, sct_pkg::ERR_NONE);
      SCAN_NUM, SCAN_FRAC: add_token(sct_pkg::K_NUMBER, tok_start, run_len, sct_pkg::ERR_NONE);
      SCAN_WORD: add_token(word_kind(), tok_start, run_len, sct_pkg::ERR_NONE);
      default: ;
    endcase
    scan_mode = SCAN_IDLE;
  endfunction

  function automatic void start_char(logic [7:0] c);
    scan_mode = SCAN_IDLE;
    case (c)
      sct_pkg::CH_SPACE, sct_pkg::CH_CR, sct_pkg::CH_TAB: ;
      sct_pkg::CH_LF:     count_line();
      sct_pkg::CH_LPAREN: add_token(sct_pkg::K_LPAREN, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_RPAREN: add_token(sct_pkg::K_RPAREN, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_LBRACK: add_token(sct_pkg::K_LBRACKET, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_RBRACK: add_token(sct_pkg::K_RBRACKET, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_LBRACE: add_token(sct_pkg::K_LBRACE, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_RBRACE: add_token(sct_pkg::K_RBRACE, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_COMMA:  add_token(sct_pkg::K_COMMA, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_DOT:    add_token(sct_pkg::K_DOT, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_SEMI:   add_token(sct_pkg::K_SEMI, src_offset, 1, sct_pkg::ERR_NONE);
      sct_pkg::CH_SLASH: begin
        scan_mode = SCAN_SLASH;
        tok_start = src_offset;
      end
      sct_pkg::CH_BANG, sct_pkg::CH_EQ, sct_pkg::CH_GT, sct_pkg::CH_LESS,
      sct_pkg::CH_MINUS, sct_pkg::CH_PLUS, sct_pkg::CH_STAR: begin
        scan_mode = SCAN_OP;
        held_op   = c;
        tok_start = src_offset;
      end
      sct_pkg::CH_QUOTE: begin
        // The string body starts after the opening quote.
        scan_mode = SCAN_STR;
        tok_start = src_offset + 1'b1;
        run_len   = '0;
      end
      default: begin
        if (char_is_digit(c)) begin
          scan_mode = SCAN_NUM;
          tok_start = src_offset;
          run_len   = 1;
        end else if (char_is_letter(c)) begin
          scan_mode = SCAN_WORD;
          tok_start = src_offset;
          run_len   = 1;
          word_head = {40'd0, c};
        end else begin
          add_token(sct_pkg::K_ERROR, src_offset, 1, sct_pkg::ERR_UNKNOWN);
        end
      end
    endcase
  endfunction

  function automatic void scan_char(logic [7:0] c);
    case (scan_mode)
      SCAN_SLASH: begin
        if (c == sct_pkg::CH_SLASH) scan_mode = SCAN_LINE_CMT;
        else if (c == sct_pkg::CH_STAR) scan_mode = SCAN_BLOCK_CMT;
        else if (c == sct_pkg::CH_EQ) begin
          add_token(sct_pkg::K_SLASH_EQ, tok_start, 2, sct_pkg::ERR_NONE);
          scan_mode = SCAN_IDLE;
        end else begin
          flush_pending();
          start_char(c);
        end
      end
      SCAN_OP: begin
        if (c == sct_pkg::CH_EQ) begin
          add_token(operator_kind(held_op) + 1'b1, tok_start, 2, sct_pkg::ERR_NONE);
          scan_mode = SCAN_IDLE;
        end else begin
          flush_pending();
          start_char(c);
        end
      end
      SCAN_NUM: begin
        if (char_is_digit(c)) grow_run();
        else if (c == sct_pkg::CH_DOT) begin
          grow_run();
          scan_mode = SCAN_FRAC;
        end else begin
          flush_pending();
          start_char(c);
        end
      end
      SCAN_FRAC: begin
        if (char_is_digit(c)) grow_run();
        else begin
          flush_pending();
          start_char(c);
        end
      end
      SCAN_WORD: begin
        if (char_is_letter(c) || char_is_digit(c)) begin
          if (run_len < 6) word_head[8 * int'(run_len) +: 8] = c;
          grow_run();
        end else begin
          flush_pending();
          start_char(c);
        end
      end
      SCAN_STR: begin
        if (c == sct_pkg::CH_QUOTE) begin
          add_token(sct_pkg::K_STRING, tok_start, run_len, sct_pkg::ERR_NONE);
          scan_mode = SCAN_IDLE;
        end else if (c == sct_pkg::CH_LF) begin
          // The broken string is reported, then the newline counts as a blank.
          add_token(sct_pkg::K_ERROR, tok_start, run_len, sct_pkg::ERR_STR_NL);
          start_char(c);
        end else if (c == sct_pkg::CH_BSLASH) begin
          grow_run();
          scan_mode = SCAN_ESC;
        end else begin
          grow_run();
        end
      end
      SCAN_ESC: begin
        grow_run();
        if (c == sct_pkg::CH_LF) count_line();
        scan_mode = SCAN_STR;
      end
      SCAN_LINE_CMT: begin
        if (c == sct_pkg::CH_LF) begin
          count_line();
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_BLOCK_CMT: if (c == sct_pkg::CH_STAR) scan_mode = SCAN_BLOCK_STAR;
      SCAN_BLOCK_STAR: begin
        if (c == sct_pkg::CH_SLASH) scan_mode = SCAN_IDLE;
        else if (c != sct_pkg::CH_STAR) scan_mode = SCAN_BLOCK_CMT;
      end
      default: start_char(c);
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] ch, logic eos);
    int n_queued;
    n_queued = expected_tokens.size();
    if (eos) begin
      if (scan_mode == SCAN_STR || scan_mode == SCAN_ESC)
        add_token(sct_pkg::K_ERROR, tok_start, run_len, sct_pkg::ERR_STR_END);
      else
        flush_pending();
      add_token(sct_pkg::K_EOF, src_offset, 0, sct_pkg::ERR_NONE);
      clear_scanner();
    end else begin
      scan_char(ch);
      src_offset++;
    end
    if (expected_tokens.size() > n_queued) expected_tokens[$].last = 1'b1;
  endfunction

  // ------------------------------------------------------------- checking

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && tok_ch.valid && tok_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        error_count++;
        $error("token_kind: expected none, got %0d", tok_ch.token_kind);
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", want.kind, tok_ch.token_kind);
        check_field("token_start", want.start, tok_ch.token_start);
        check_field("token_length", want.length, tok_ch.token_length);
        check_field("token_line", want.line, tok_ch.token_line);
        check_field("error_kind", want.err, tok_ch.error_kind);
        check_field("last_of_run", want.last, tok_ch.last_of_run);
      end
    end
    tok_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ------------------------------------------------------------- stimulus

  task automatic send_request(logic [7:0] ch, logic eos);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.source_byte   <= ch;
    in_ch.end_of_source <= eos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_tokens(ch, eos);
    sent_items++;
  endtask

  function automatic void push_text(string s);
    foreach (s[i]) src_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    return 8'h5F;
  endfunction

  function automatic logic [7:0] random_alnum();
    if ($urandom_range(9) < 2) return 8'(8'h30 + $urandom_range(9));
    return random_letter();
  endfunction

  function automatic logic [7:0] random_printable();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return (c == sct_pkg::CH_QUOTE || c == sct_pkg::CH_BSLASH) ? 8'h71 : c;
  endfunction

  // Appends one lexeme; a closing lexeme may be left open so that the end
  // request finds the scanner in the middle of it.
  function automatic void add_lexeme(logic closing);
    int pick;
    int r;
    logic [7:0] c;
    string kw;
    pick = $urandom_range(99);
    if (pick < 15) begin
      push_text(keyword_text[$urandom_range(5)]);
    end else if (pick < 30) begin
      if ($urandom_range(1)) begin
        kw = keyword_text[$urandom_range(5)];
        case ($urandom_range(2))
          0: begin
            push_text(kw);
            src_text.push_back(random_alnum());
          end
          1: push_text(kw.substr(0, kw.len() - 2));
          default: begin
            kw[0] = kw[0] - 8'h20;
            push_text(kw);
          end
        endcase
      end else begin
        src_text.push_back(random_letter());
        repeat ($urandom_range(7)) src_text.push_back(random_alnum());
      end
    end else if (pick < 43) begin
      repeat ($urandom_range(1, 6)) src_text.push_back(8'(8'h30 + $urandom_range(9)));
      if ($urandom_range(99) < 40) begin
        src_text.push_back(sct_pkg::CH_DOT);
        repeat ($urandom_range(3)) src_text.push_back(8'(8'h30 + $urandom_range(9)));
      end
    end else if (pick < 53) begin
      src_text.push_back(sct_pkg::CH_QUOTE);
      repeat ($urandom_range(8)) begin
        r = $urandom_range(99);
        if (r < 15) begin
          src_text.push_back(sct_pkg::CH_BSLASH);
          case ($urandom_range(3))
            0: src_text.push_back(sct_pkg::CH_QUOTE);
            1: src_text.push_back(sct_pkg::CH_LF);
            2: src_text.push_back(sct_pkg::CH_BSLASH);
            default: src_text.push_back(random_printable());
          endcase
        end else if (r < 25) begin
          c = 8'($urandom_range(1, 255));
          src_text.push_back((c == sct_pkg::CH_QUOTE || c == sct_pkg::CH_BSLASH ||
                              c == sct_pkg::CH_LF) ? 8'h78 : c);
        end else begin
          src_text.push_back(random_printable());
        end
      end
      r = $urandom_range(99);
      if (closing && r < 15) ;
      else if (closing && r < 25) src_text.push_back(sct_pkg::CH_BSLASH);
      else if (r < 35) src_text.push_back(sct_pkg::CH_LF);
      else src_text.push_back(sct_pkg::CH_QUOTE);
    end else if (pick < 72) begin
      push_text(operator_text[$urandom_range(15)]);
    end else if (pick < 82) begin
      src_text.push_back(punct_text[$urandom_range(8)]);
    end else if (pick < 87) begin
      push_text("//");
      repeat ($urandom_range(10)) begin
        c = 8'($urandom_range(1, 255));
        src_text.push_back(c == sct_pkg::CH_LF ? 8'h63 : c);
      end
      if (!closing || $urandom_range(1)) src_text.push_back(sct_pkg::CH_LF);
    end else if (pick < 93) begin
      push_text("/*");
      repeat ($urandom_range(10)) begin
        r = $urandom_range(99);
        if (r < 20) src_text.push_back(sct_pkg::CH_STAR);
        else if (r < 35) src_text.push_back(sct_pkg::CH_LF);
        else if (r < 45) src_text.push_back(sct_pkg::CH_SLASH);
        else src_text.push_back(random_printable());
      end
      if (!closing || $urandom_range(99) >= 30) begin
        if ($urandom_range(1)) src_text.push_back(sct_pkg::CH_STAR);
        push_text("*/");
      end
    end else begin
      src_text.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void add_separator();
    int r;
    r = $urandom_range(99);
    if (r < 50) src_text.push_back(sct_pkg::CH_SPACE);
    else if (r < 65) ;
    else if (r < 78) src_text.push_back(sct_pkg::CH_LF);
    else if (r < 86) src_text.push_back(sct_pkg::CH_TAB);
    else if (r < 93) src_text.push_back(sct_pkg::CH_CR);
    else push_text("  ");
  endfunction

  task automatic send_source();
    foreach (src_text[i]) send_request(src_text[i], 1'b0);
    send_request(8'($urandom), 1'b1);
  endtask

  // ----------------------------------------------------------------- tests

  // Lone slash, a number ending in its dot, an escaped newline in a string,
  // a string broken by a newline, a block comment across lines, byte zero and
  // a high byte, and a string still open at the end of the source.
  task automatic test_special_cases();
    send_gap_pct = 0;
    stall_pct    = 0;
    src_text.delete();
    push_text("a/b 12.;\"x\\\ny\n/*\n**/");
    src_text.push_back(8'h00);
    src_text.push_back(8'hFF);
    push_text("\"z");
    send_source();
  endtask

  task automatic test_random_sources(int gap_pct, int stall, int item_goal);
    int first_item;
    int n_lex;
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    first_item   = sent_items;
    while (sent_items - first_item < item_goal) begin
      src_text.delete();
      n_lex = $urandom_range(2, 24);
      for (int i = 0; i < n_lex; i++) begin
        add_lexeme(i == n_lex - 1);
        if (i != n_lex - 1 || $urandom_range(1)) add_separator();
      end
      send_source();
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.source_byte   = '0;
    in_ch.end_of_source = 1'b0;
    error_count         = 0;
    sent_items          = 0;
    send_gap_pct        = 0;
    stall_pct           = 0;
    clear_scanner();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_random_sources(0, 0, 400);
    test_random_sources(49, 0, 400);
    test_random_sources(0, 49, 400);
    test_random_sources(12, 12, 400);

    in_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[source_code_tokenizer] OK");
    end else begin
      $display("[source_code_tokenizer] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sct_pkg.sv
rtl/core/sct_if.sv
rtl/core/source_code_tokenizer.sv
tb/source_code_tokenizer_test.sv
